// ===== rtl/fqbrr_pkg.sv =====
// ----------------------------------------------------------------------------
// Four-queue burst round-robin scheduler package
// Shared widths, command and status codes, register indexes and the result
// descriptor that travels from the scheduler to the output stage.
// ----------------------------------------------------------------------------
package fqbrr_pkg;

  // Field widths.
  localparam int unsigned NumDirs   = 4;
  localparam int unsigned DirW      = 2;
  localparam int unsigned TagW      = 16;
  localparam int unsigned DurW      = 8;
  localparam int unsigned EntryW    = TagW + DurW;
  localparam int unsigned LimitW    = 8;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 32;

  // Default number of entries per queue.
  localparam int unsigned QueueDepthDef = 16;

  // Input command codes.
  typedef enum logic {
    CmdEnqueue = 1'b0,
    CmdServe   = 1'b1
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    StEnqueued = 2'd0,
    StServed   = 2'd1,
    StEmpty    = 2'd2,
    StFull     = 2'd3
  } status_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgStartDir   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBurstLimit = 1'b1;

  // Result descriptor; the entry payload comes from the store read register.
  typedef struct packed {
    status_e           status;
    logic [DirW-1:0]   dir;
    logic              turn_start;
  } result_meta_t;

endpackage

// ===== rtl/four_queue_burst_round_robin_top.sv =====
// ----------------------------------------------------------------------------
// Four-queue burst round-robin scheduler, top level
// Stream wrapper with the result register around the scheduler and store.
// ----------------------------------------------------------------------------
// Every input item produces exactly one result item. An item is decided in
// the cycle it is accepted and its result appears on the master side on the
// next cycle; one item per cycle is accepted as long as the result register
// is empty or is being taken. Each item makes at most one entry memory
// access (a push or a pop in the accept cycle, with the read data
// registered). Enqueue items carry direction, tag and duration; serve items
// only need the command. The user must make configuration writes while the
// block is idle; the block itself does not enforce it.
module four_queue_burst_round_robin_top
  import fqbrr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input items.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: direction[1:0], entry_tag[17:2], entry_duration[25:18], zero[31:26]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: command[0]
  input  logic                s_axis_tuser,
  // Result items.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: served_direction[1:0], served_tag[17:2], served_duration[25:18],
  //        turn_start[26], zero[31:27]
  output logic [OutDataW-1:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]          m_axis_tuser
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  logic              accept;
  cmd_e              cmd;
  logic [DirW-1:0]   in_dir;
  logic [EntryW-1:0] in_entry;
  logic              wr_en;
  logic              rd_en;
  logic [DirW-1:0]   mem_dir;
  logic [PtrW-1:0]   mem_slot;
  logic [EntryW-1:0] wdata;
  logic [EntryW-1:0] rdata;
  result_meta_t      meta;
  result_meta_t      meta_q;
  logic              valid_q;
  logic [TagW-1:0]   out_tag;
  logic [DurW-1:0]   out_dur;

  // Input unpacking; entry is tag above duration.
  assign cmd      = cmd_e'(s_axis_tuser);
  assign in_dir   = s_axis_tdata[1:0];
  assign in_entry = {s_axis_tdata[17:2], s_axis_tdata[25:18]};

  // Accept whenever the result register is free or drains this cycle.
  assign s_axis_tready = !valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  fqbrr_sched #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .cmd_i      (cmd),
    .dir_i      (in_dir),
    .entry_i    (in_entry),
    .wr_en_o    (wr_en),
    .rd_en_o    (rd_en),
    .mem_dir_o  (mem_dir),
    .mem_slot_o (mem_slot),
    .wdata_o    (wdata),
    .meta_o     (meta)
  );

  fqbrr_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .wr_en_i (wr_en),
    .rd_en_i (rd_en),
    .dir_i   (mem_dir),
    .slot_i  (mem_slot),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  // Result descriptor; the entry payload sits in the store read register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      meta_q <= meta;
    end
  end

  // Payload fields read as zero unless an entry was served.
  assign out_tag = (meta_q.status == StServed) ? rdata[EntryW-1:DurW] : '0;
  assign out_dur = (meta_q.status == StServed) ? rdata[DurW-1:0] : '0;

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = meta_q.status;
  assign m_axis_tdata  = {5'b0, meta_q.turn_start, out_dur, out_tag, meta_q.dir};

endmodule

// ===== rtl/fqbrr_store.sv =====
// ----------------------------------------------------------------------------
// Entry store
// Single-port entry memory for all four queues with a registered read port.
// Queue d owns the rows d*QUEUE_DEPTH up to d*QUEUE_DEPTH+QUEUE_DEPTH-1.
// ----------------------------------------------------------------------------
module fqbrr_store
  import fqbrr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic                           rd_en_i,
  input  logic [DirW-1:0]                dir_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] slot_i,
  input  logic [EntryW-1:0]              wdata_i,
  output logic [EntryW-1:0]              rdata_o
);

  localparam int unsigned Rows  = NumDirs * QUEUE_DEPTH;
  localparam int unsigned AddrW = $clog2(Rows);

  logic [EntryW-1:0] mem_q [Rows];
  logic [EntryW-1:0] rdata_q;
  logic [AddrW-1:0]  addr;

  // Row address of the queue slot.
  assign addr = AddrW'(dir_i) * AddrW'(QUEUE_DEPTH) + AddrW'(slot_i);

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fqbrr_sched.sv =====
// ----------------------------------------------------------------------------
// Queue scheduler
// Keeps the head pointers and fill counts of the four queues, the current
// turn, its burst credit and the configuration, and decides each item.
// ----------------------------------------------------------------------------
module fqbrr_sched
  import fqbrr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration writes.
  input  logic                           cfg_we_i,
  input  logic [CfgIdxW-1:0]             cfg_idx_i,
  input  logic [CfgDataW-1:0]            cfg_data_i,
  // Accepted item.
  input  logic                           accept_i,
  input  cmd_e                           cmd_i,
  input  logic [DirW-1:0]                dir_i,
  input  logic [EntryW-1:0]              entry_i,
  // Entry store access.
  output logic                           wr_en_o,
  output logic                           rd_en_o,
  output logic [DirW-1:0]                mem_dir_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_slot_o,
  output logic [EntryW-1:0]              wdata_o,
  // Result of the accepted item.
  output result_meta_t                   meta_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  logic [CntW-1:0]   cnt_q  [NumDirs];
  logic [CntW-1:0]   cnt_d  [NumDirs];
  logic [PtrW-1:0]   head_q [NumDirs];
  logic [PtrW-1:0]   head_d [NumDirs];
  logic [DirW-1:0]   turn_q, turn_d;
  logic [LimitW-1:0] credit_q, credit_d;
  logic              open_q, open_d;
  logic [LimitW-1:0] limit_q;

  logic [LimitW-1:0] limit_eff;
  logic [LimitW-1:0] cfg_limit_eff;
  logic [NumDirs-1:0] nonempty;
  logic              in_full;
  logic [SumW-1:0]   tail_sum;
  logic [PtrW-1:0]   tail_slot;
  logic              skip;
  logic              any_found;
  logic [DirW-1:0]   sel_dir;
  logic [DirW-1:0]   cand;
  logic [CntW-1:0]   cnt_after;
  logic [PtrW-1:0]   head_next;
  logic [LimitW-1:0] credit_base;
  logic [LimitW-1:0] credit_dec;
  logic              close_now;
  logic              do_push;
  logic              do_pop;

  // A stored burst limit of zero acts as one.
  assign limit_eff     = (limit_q == '0) ? LimitW'(1) : limit_q;
  assign cfg_limit_eff = (cfg_data_i == '0) ? LimitW'(1) : cfg_data_i;

  // Per-queue occupancy flags.
  always_comb begin
    for (int i = 0; i < NumDirs; i++) begin
      nonempty[i] = (cnt_q[i] != '0);
    end
  end

  // Enqueue: tail slot of the named queue, wrapped once.
  assign in_full  = (cnt_q[dir_i] == CntW'(QUEUE_DEPTH));
  assign tail_sum = SumW'(head_q[dir_i]) + SumW'(cnt_q[dir_i]);
  assign tail_slot = (tail_sum >= SumW'(QUEUE_DEPTH)) ?
                     PtrW'(tail_sum - SumW'(QUEUE_DEPTH)) : PtrW'(tail_sum);

  // Serve: stay on the current turn or skip to the next non-empty queue.
  always_comb begin
    skip      = !nonempty[turn_q];
    any_found = nonempty[turn_q];
    sel_dir   = turn_q;
    cand      = turn_q;
    for (int k = 1; k < NumDirs; k++) begin
      cand = turn_q + DirW'(k);
      if (!any_found && nonempty[cand]) begin
        any_found = 1'b1;
        sel_dir   = cand;
      end
    end
  end

  // Pop bookkeeping and turn hand-over.
  assign cnt_after   = cnt_q[sel_dir] - CntW'(1);
  assign head_next   = (head_q[sel_dir] == PtrW'(QUEUE_DEPTH - 1)) ?
                       '0 : head_q[sel_dir] + PtrW'(1);
  assign credit_base = skip ? limit_eff : credit_q;
  assign credit_dec  = (credit_base != '0) ? credit_base - LimitW'(1) : credit_base;
  assign close_now   = (credit_dec == '0) || (cnt_after == '0);

  assign do_push = accept_i && (cmd_i == CmdEnqueue) && !in_full;
  assign do_pop  = accept_i && (cmd_i == CmdServe) && any_found;

  // Next state.
  always_comb begin
    for (int i = 0; i < NumDirs; i++) begin
      cnt_d[i]  = cnt_q[i];
      head_d[i] = head_q[i];
    end
    turn_d   = turn_q;
    credit_d = credit_q;
    open_d   = open_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStartDir: begin
          turn_d   = cfg_data_i[DirW-1:0];
          credit_d = limit_eff;
          open_d   = 1'b0;
        end
        CfgBurstLimit: begin
          if (!open_q) begin
            credit_d = cfg_limit_eff;
          end
        end
        default: ;
      endcase
    end else if (do_push) begin
      cnt_d[dir_i] = cnt_q[dir_i] + CntW'(1);
    end else if (do_pop) begin
      cnt_d[sel_dir]  = cnt_after;
      head_d[sel_dir] = head_next;
      if (close_now) begin
        turn_d   = sel_dir + DirW'(1);
        credit_d = limit_eff;
        open_d   = 1'b0;
      end else begin
        turn_d   = sel_dir;
        credit_d = credit_dec;
        open_d   = 1'b1;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDirs; i++) begin
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
      end
      turn_q   <= '0;
      credit_q <= LimitW'(1);
      open_q   <= 1'b0;
      limit_q  <= LimitW'(1);
    end else begin
      for (int i = 0; i < NumDirs; i++) begin
        cnt_q[i]  <= cnt_d[i];
        head_q[i] <= head_d[i];
      end
      turn_q   <= turn_d;
      credit_q <= credit_d;
      open_q   <= open_d;
      if (cfg_we_i && (cfg_idx_i == CfgBurstLimit)) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Store access.
  assign wr_en_o    = do_push;
  assign rd_en_o    = do_pop;
  assign mem_dir_o  = (cmd_i == CmdEnqueue) ? dir_i : sel_dir;
  assign mem_slot_o = (cmd_i == CmdEnqueue) ? tail_slot : head_q[sel_dir];
  assign wdata_o    = entry_i;

  // Result descriptor.
  always_comb begin
    meta_o.dir        = '0;
    meta_o.turn_start = 1'b0;
    if (cmd_i == CmdEnqueue) begin
      meta_o.status = in_full ? StFull : StEnqueued;
    end else if (!any_found) begin
      meta_o.status = StEmpty;
    end else begin
      meta_o.status     = StServed;
      meta_o.dir        = sel_dir;
      meta_o.turn_start = skip || !open_q;
    end
  end

  // No queue ever holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CntW'(QUEUE_DEPTH)) && (cnt_q[1] <= CntW'(QUEUE_DEPTH)) &&
    (cnt_q[2] <= CntW'(QUEUE_DEPTH)) && (cnt_q[3] <= CntW'(QUEUE_DEPTH)))
    else $error("queue count above depth");

  // A closed turn always holds a full credit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (credit_q == limit_eff))
    else $error("closed turn without reloaded credit");

  // A pop lowers the count of the served queue by one on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |=> (cnt_q[$past(sel_dir)] == $past(cnt_after)))
    else $error("pop did not decrement the queue count");

  // An open turn never has its credit used up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (credit_q != '0))
    else $error("open turn with no credit left");

endmodule
